FILE: design/brl_pkg.sv
package brl_pkg;

  // default list capacity
  localparam int DEPTH_DEF = 8;
  // a dump shows at most this many entries
  localparam int MAX_DUMP = 8;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int CNT_OUT_W = 4;

  // request codes
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef logic signed [31:0] key_t;
  typedef logic [63:0]        tag_t;
  typedef logic [31:0]        salary_t;

  // one stored record, also the memory word
  typedef struct packed {
    key_t    key;
    tag_t    name;
    tag_t    address;
    salary_t salary;
    tag_t    report;
  } rec_t;

endpackage

FILE: design/brl_if.sv
interface brl_req_if import brl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  key_t                 rec_key;
  tag_t                 rec_name;
  tag_t                 rec_address;
  salary_t              rec_salary;
  tag_t                 rec_report;
  logic [POS_W-1:0]     position;

  modport source (
    output valid, func, rec_key, rec_name, rec_address, rec_salary, rec_report, position,
    input  ready
  );
  modport sink (
    input  valid, func, rec_key, rec_name, rec_address, rec_salary, rec_report, position,
    output ready
  );
endinterface

interface brl_rsp_if import brl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  key_t                 out_key;
  tag_t                 out_name;
  tag_t                 out_address;
  salary_t              out_salary;
  tag_t                 out_report;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 last;

  modport source (
    output valid, status, out_key, out_name, out_address, out_salary, out_report,
           entry_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_key, out_name, out_address, out_salary, out_report,
           entry_count, last,
    output ready
  );
endinterface

FILE: design/brl_ram.sv
module brl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bounded_record_list.sv
// flow: a request word is latched in S_IDLE, decoded in S_DEC and its result word is loaded
//   into the output register from S_OUT; search and delete first scan entries, delete and insert move them
// throughput: one request at a time; a dump addresses each entry in S_DREAD and emits it in S_DOUT,
//   set by the single read port of the record memory, and waits in S_DOUT while the output is held
// reset: count clears to zero at once; record memory is not cleared, no entry is read before
//   it is written
module bounded_record_list import brl_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  brl_req_if.sink   req,
  brl_rsp_if.source rsp
);

  // address width of the memory, count width (holds DEPTH itself)
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // controller states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request word
  localparam logic [2:0] S_DEC   = 3'd1;  // decode latched request
  localparam logic [2:0] S_SCAN  = 3'd2;  // walk entries looking for a match
  localparam logic [2:0] S_SHL   = 3'd3;  // close the gap after a delete
  localparam logic [2:0] S_SHR   = 3'd4;  // open a slot for an insert
  localparam logic [2:0] S_OUT   = 3'd5;  // hand single result to output register
  localparam logic [2:0] S_DREAD = 3'd6;  // dump: address one entry
  localparam logic [2:0] S_DOUT  = 3'd7;  // dump: emit that entry

  logic [2:0]          state;
  logic [CW-1:0]       count;

  // latched request
  logic [FUNC_W-1:0]   cur_func;
  rec_t                cur_rec;
  logic [POS_W-1:0]    cur_pos;

  // walk pointers: idx addresses the memory, pidx names the entry now on rd_data
  logic [CW-1:0]       idx;
  logic [CW-1:0]       pidx;
  logic                pvalid;
  logic                rd_done;

  // pending single result
  logic [STATUS_W-1:0] res_status;
  rec_t                res_rec;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  rec_t                out_rec;
  logic [CNT_OUT_W-1:0] out_count;
  logic                out_last;

  // memory ports
  logic                we;
  logic [AW-1:0]       waddr;
  rec_t                wdata;
  logic [AW-1:0]       raddr;
  rec_t                rd_data;

  // derived control
  logic                full;
  logic                bad_pos;
  logic [CW-1:0]       pos_w;
  logic                at_end;
  logic                hit;
  logic                more;
  logic                out_free;
  logic                dump_last;
  logic [CW-1:0]       pidx_dec;
  logic [CW-1:0]       pidx_inc;
  logic [CW:0]         idx_inc_wide;

  brl_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign full     = (count == CW'(DEPTH));
  assign bad_pos  = (32'(cur_pos) > 32'(count));
  assign pos_w    = CW'(cur_pos);
  assign at_end   = (32'(cur_pos) == 32'(count));
  assign more     = (idx < count);
  assign out_free = !out_valid || rsp.ready;
  assign pidx_dec = pidx - CW'(1);
  assign pidx_inc = pidx + CW'(1);
  assign raddr    = idx[AW-1:0];

  // search matches on key alone, delete on key, name and report
  always_comb begin
    hit = (rd_data.key == cur_rec.key);
    if (cur_func == FN_DELETE) begin
      hit = hit && (rd_data.name == cur_rec.name) && (rd_data.report == cur_rec.report);
    end
  end

  // dump ends at the last entry or at the dump limit
  assign idx_inc_wide = {1'b0, idx} + (CW + 1)'(1);
  assign dump_last    = (idx_inc_wide == {1'b0, count}) || (32'(idx) == MAX_DUMP - 1);

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = cur_rec;
    case (state)
      S_DEC: begin
        if (cur_func == FN_APPEND && !full) begin
          we = 1'b1;
        end else if (cur_func == FN_INSERT && !full && !bad_pos && at_end) begin
          we = 1'b1;
        end
      end
      S_SHL: begin
        // entry pidx moves down one slot
        if (pvalid) begin
          we    = 1'b1;
          waddr = pidx_dec[AW-1:0];
          wdata = rd_data;
        end
      end
      S_SHR: begin
        // entry pidx moves up one slot, then the new record lands at the position
        if (pvalid) begin
          we    = 1'b1;
          waddr = pidx_inc[AW-1:0];
          wdata = rd_data;
        end else if (rd_done) begin
          we    = 1'b1;
          waddr = pos_w[AW-1:0];
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pvalid    <= 1'b0;
      rd_done   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // word taken and no new word loaded this cycle
      if (out_valid && rsp.ready && state != S_OUT && state != S_DOUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_func        <= req.func;
            cur_rec.key     <= req.rec_key;
            cur_rec.name    <= req.rec_name;
            cur_rec.address <= req.rec_address;
            cur_rec.salary  <= req.rec_salary;
            cur_rec.report  <= req.rec_report;
            cur_pos         <= req.position;
            state           <= S_DEC;
          end
        end
        S_DEC: begin
          pvalid  <= 1'b0;
          rd_done <= 1'b0;
          // an insert walks down from the tail, everything else up from the head
          idx     <= (cur_func == FN_INSERT) ? count - CW'(1) : '0;
          res_rec <= '0;
          case (cur_func)
            FN_APPEND: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                count      <= count + CW'(1);
              end
              state <= S_OUT;
            end
            FN_SEARCH, FN_DELETE: begin
              state <= S_SCAN;
            end
            FN_INSERT: begin
              if (full) begin
                res_status <= ST_FULL;
                state      <= S_OUT;
              end else if (bad_pos) begin
                res_status <= ST_BAD_POS;
                state      <= S_OUT;
              end else if (at_end) begin
                res_status <= ST_OK;
                count      <= count + CW'(1);
                state      <= S_OUT;
              end else begin
                state <= S_SHR;
              end
            end
            FN_DUMP: begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_OUT;
              end else begin
                state <= S_DREAD;
              end
            end
            default: begin
              // unused codes give no word
              state <= S_IDLE;
            end
          endcase
        end
        S_SCAN: begin
          if (pvalid && hit) begin
            if (cur_func == FN_SEARCH) begin
              res_status <= ST_OK;
              res_rec    <= rd_data;
              state      <= S_OUT;
            end else begin
              // start closing the gap with the entry after the match
              idx    <= pidx_inc;
              pvalid <= 1'b0;
              state  <= S_SHL;
            end
          end else if (!pvalid && !more) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_OUT;
          end else begin
            pvalid <= more;
            pidx   <= idx;
            if (more) begin
              idx <= idx + CW'(1);
            end
          end
        end
        S_SHL: begin
          if (!pvalid && !more) begin
            count      <= count - CW'(1);
            res_status <= ST_OK;
            state      <= S_OUT;
          end else begin
            pvalid <= more;
            pidx   <= idx;
            if (more) begin
              idx <= idx + CW'(1);
            end
          end
        end
        S_SHR: begin
          if (rd_done && !pvalid) begin
            count      <= count + CW'(1);
            res_status <= ST_OK;
            state      <= S_OUT;
          end else if (rd_done) begin
            pvalid <= 1'b0;
          end else begin
            // read downward from the tail to the insert position
            pvalid <= 1'b1;
            pidx   <= idx;
            if (idx == pos_w) begin
              rd_done <= 1'b1;
            end else begin
              idx <= idx - CW'(1);
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_rec    <= res_rec;
            out_count  <= CNT_OUT_W'(count);
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_DREAD: begin
          state <= S_DOUT;
        end
        S_DOUT: begin
          // idx stays put while waiting, so rd_data holds
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= ST_OK;
            out_rec    <= rd_data;
            out_count  <= CNT_OUT_W'(count);
            out_last   <= dump_last;
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_DREAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // handshake and payload
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.out_key     = out_rec.key;
  assign rsp.out_name    = out_rec.name;
  assign rsp.out_address = out_rec.address;
  assign rsp.out_salary  = out_rec.salary;
  assign rsp.out_report  = out_rec.report;
  assign rsp.entry_count = out_count;
  assign rsp.last        = out_last;

endmodule

FILE: tb/sv/bounded_record_list_tb.sv
`timescale 1ns / 1ps

module bounded_record_list_tb;
  import brl_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // longest request is a delete near the head of a full list, with margin
  localparam int SETTLE_CYCLES = 60;
  // receiver hold-off, started once enough requests are in
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 80;

  // codes the block must ignore without answering
  localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_C = 3'd7;

  // one request word plus its pacing marks
  typedef struct {
    logic [FUNC_W-1:0] func;
    rec_t              rec;
    logic [POS_W-1:0]  pos;
    bit                drain;  // hold this word until every answer is in
    bit                calm;   // no idling from here on
  } req_word_t;

  // one answer word
  typedef struct {
    logic [STATUS_W-1:0]  status;
    rec_t                 rec;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brl_req_if req_bus ();
  brl_rsp_if rsp_bus ();

  bounded_record_list #(.DEPTH(LIST_DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // request words waiting to be offered, answers still owed by the block
  req_word_t backlog[$];
  rsp_word_t due_results[$];

  // shadow of the list contents
  rec_t model_rec [LIST_DEPTH];
  int   model_count = 0;

  int  mismatch_cnt = 0;
  int  accepted_reqs = 0;
  int  cycle_cnt = 0;
  bit  req_taken = 1'b0;
  bit  calm_phase = 1'b0;
  req_word_t on_bus;

  // generator pools: a record "identity" ties key, name and report together
  key_t key_pool [6];
  tag_t name_pool [6];
  tag_t report_pool [6];
  bit   gen_calm = 1'b0;
  bit   gen_drain = 1'b0;

  function automatic tag_t rand_tag();
    return {$urandom, $urandom};
  endfunction

  function automatic rec_t pick_rec(int id, bit odd_name);
    rec_t r;
    r.key     = key_pool[id];
    r.name    = odd_name ? rand_tag() : name_pool[id];
    r.address = rand_tag();
    r.salary  = $urandom;
    r.report  = report_pool[id];
    return r;
  endfunction

  function automatic void push_req(logic [FUNC_W-1:0] fn, rec_t r, int pos);
    backlog.push_back('{fn, r, pos[POS_W-1:0], gen_drain, gen_calm});
    gen_drain = 1'b0;
  endfunction

  // queue one expected answer; count is taken after the list update
  function automatic void expect_word(logic [STATUS_W-1:0] st, rec_t r, logic lst);
    due_results.push_back('{st, r, model_count[CNT_OUT_W-1:0], lst});
  endfunction

  // list behavior for one accepted request word
  function automatic void apply_request(req_word_t w);
    rec_t none;
    int   hit;
    int   n;
    none = '0;
    hit  = -1;
    case (w.func)
      FN_APPEND: begin
        if (model_count >= LIST_DEPTH) begin
          expect_word(ST_FULL, none, 1'b1);
        end else begin
          model_rec[model_count] = w.rec;
          model_count++;
          expect_word(ST_OK, none, 1'b1);
        end
      end
      FN_SEARCH: begin
        // scan backward so the first match wins
        for (int i = model_count - 1; i >= 0; i--)
          if (model_rec[i].key == w.rec.key) hit = i;
        if (hit >= 0) expect_word(ST_OK, model_rec[hit], 1'b1);
        else expect_word(ST_NOT_FOUND, none, 1'b1);
      end
      FN_DELETE: begin
        for (int i = model_count - 1; i >= 0; i--)
          if (model_rec[i].key == w.rec.key && model_rec[i].name == w.rec.name &&
              model_rec[i].report == w.rec.report) hit = i;
        if (hit >= 0) begin
          for (int i = hit; i < model_count - 1; i++) model_rec[i] = model_rec[i + 1];
          model_count--;
          expect_word(ST_OK, none, 1'b1);
        end else begin
          expect_word(ST_NOT_FOUND, none, 1'b1);
        end
      end
      FN_INSERT: begin
        if (model_count >= LIST_DEPTH) begin
          expect_word(ST_FULL, none, 1'b1);
        end else if (int'(w.pos) > model_count) begin
          expect_word(ST_BAD_POS, none, 1'b1);
        end else begin
          for (int i = model_count; i > int'(w.pos); i--) model_rec[i] = model_rec[i - 1];
          model_rec[w.pos] = w.rec;
          model_count++;
          expect_word(ST_OK, none, 1'b1);
        end
      end
      FN_DUMP: begin
        if (model_count == 0) begin
          expect_word(ST_EMPTY, none, 1'b1);
        end else begin
          n = (model_count < MAX_DUMP) ? model_count : MAX_DUMP;
          for (int i = 0; i < n; i++) expect_word(ST_OK, model_rec[i], i == n - 1);
        end
      end
      default: ;  // unused codes: no answer, list untouched
    endcase
  endfunction

  function automatic void check_field(string fld, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  // sender: new word at the falling edge once the last one is taken
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (backlog.size() == 0 || (backlog[0].drain && due_results.size() != 0)) begin
        // nothing to send, or pausing until the block has answered everything
        req_bus.valid <= 1'b0;
      end else if (!backlog[0].calm && $urandom_range(0, 3) == 0) begin
        // idle burst, its length drawn at random into gap_left
        gap_left = $urandom_range(0, 4);
        req_bus.valid <= 1'b0;
      end else begin
        on_bus = backlog.pop_front();
        req_bus.valid       <= 1'b1;
        req_bus.func        <= on_bus.func;
        req_bus.rec_key     <= on_bus.rec.key;
        req_bus.rec_name    <= on_bus.rec.name;
        req_bus.rec_address <= on_bus.rec.address;
        req_bus.rec_salary  <= on_bus.rec.salary;
        req_bus.rec_report  <= on_bus.rec.report;
        req_bus.position    <= on_bus.pos;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
      // block fills up and must stall its request side
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // accepted request words feed the shadow list, answer words are checked
  always @(posedge clk) begin
    req_word_t taken;
    rsp_word_t head;
    if (!rst && req_bus.valid && req_bus.ready) begin
      taken.func        = req_bus.func;
      taken.rec.key     = req_bus.rec_key;
      taken.rec.name    = req_bus.rec_name;
      taken.rec.address = req_bus.rec_address;
      taken.rec.salary  = req_bus.rec_salary;
      taken.rec.report  = req_bus.rec_report;
      taken.pos         = req_bus.position;
      apply_request(taken);
      req_taken = 1'b1;
      calm_phase = on_bus.calm;
      accepted_reqs++;
    end
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: answer word with none expected, status %0d key %h count %0d", $time,
                 rsp_bus.status, rsp_bus.out_key, rsp_bus.entry_count);
        mismatch_cnt++;
      end else begin
        head = due_results.pop_front();
        check_field("status", head.status, rsp_bus.status);
        check_field("out_key", head.rec.key, rsp_bus.out_key);
        check_field("out_name", head.rec.name, rsp_bus.out_name);
        check_field("out_address", head.rec.address, rsp_bus.out_address);
        check_field("out_salary", head.rec.salary, rsp_bus.out_salary);
        check_field("out_report", head.rec.report, rsp_bus.out_report);
        check_field("entry_count", head.count, rsp_bus.entry_count);
        check_field("last", head.last, rsp_bus.last);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rec_t r;
    int   sel;
    int   id;
    bit   grow;

    // known levels before the first falling edge
    req_bus.valid       = 1'b0;
    req_bus.func        = FN_APPEND;
    req_bus.rec_key     = '0;
    req_bus.rec_name    = '0;
    req_bus.rec_address = '0;
    req_bus.rec_salary  = '0;
    req_bus.rec_report  = '0;
    req_bus.position    = '0;
    rsp_bus.ready       = 1'b0;

    // identity 0 is all-low, identity 1 all-high (signed min and max key); keys 2 and 3 are -1 and 0, the rest random
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = -32'sd1;
    key_pool[3] = 32'sd0;
    key_pool[4] = $urandom;
    key_pool[5] = $urandom;
    name_pool[0] = '0;
    name_pool[1] = '1;
    report_pool[0] = '0;
    report_pool[1] = '1;
    for (int i = 2; i < 6; i++) begin
      name_pool[i]   = rand_tag();
      report_pool[i] = rand_tag();
    end

    // empty list corner cases
    push_req(FN_DUMP, pick_rec(0, 0), 0);
    push_req(FN_SEARCH, pick_rec(0, 0), 0);
    push_req(FN_DELETE, pick_rec(0, 0), 0);
    push_req(FN_INSERT, pick_rec(0, 0), 8);
    push_req(FN_INSERT, pick_rec(0, 0), 1);
    // all-low record at the head, all-high record appended
    r = pick_rec(0, 0);
    r.address = '0;
    r.salary  = '0;
    push_req(FN_INSERT, r, 0);
    r = pick_rec(1, 0);
    r.address = '1;
    r.salary  = '1;
    push_req(FN_APPEND, r, 0);
    // insert at the tail and in the middle
    push_req(FN_INSERT, pick_rec(2, 0), 2);
    push_req(FN_INSERT, pick_rec(3, 0), 1);
    // duplicate key: search must return the earlier one
    push_req(FN_APPEND, pick_rec(2, 0), 0);
    push_req(FN_SEARCH, pick_rec(2, 0), 0);
    push_req(FN_SEARCH, pick_rec(4, 0), 0);
    // delete needs key, name and report to agree
    r = pick_rec(3, 0);
    r.name = ~r.name;
    push_req(FN_DELETE, r, 0);
    r = pick_rec(3, 0);
    r.report = ~r.report;
    push_req(FN_DELETE, r, 0);
    push_req(FN_DELETE, pick_rec(3, 0), 0);
    // unused codes
    push_req(FN_RSVD_A, pick_rec(1, 0), 8);
    push_req(FN_RSVD_B, pick_rec(1, 0), 8);
    push_req(FN_RSVD_C, pick_rec(1, 0), 8);
    // fill up, then hit the full cases and dump all entries
    for (int j = 4; j < 8; j++) push_req(FN_APPEND, pick_rec(j % 6, 0), 0);
    push_req(FN_APPEND, pick_rec(5, 0), 0);
    push_req(FN_INSERT, pick_rec(5, 0), 0);
    push_req(FN_DUMP, pick_rec(0, 0), 0);
    push_req(FN_DELETE, pick_rec(0, 0), 0);

    // random part, alternating growth and shrink stretches
    gen_drain = 1'b1;
    for (int k = 0; k < 300; k++) begin
      if (k == 150) gen_drain = 1'b1;
      if (k >= 240) gen_calm = 1'b1;
      grow = ((k / 30) % 2) == 0;
      sel  = $urandom_range(0, 99);
      id   = $urandom_range(0, 5);
      r    = pick_rec(id, $urandom_range(0, 6) == 0);
      if (sel < 3) begin
        case ($urandom_range(0, 2))
          0:       push_req(FN_RSVD_A, r, $urandom_range(0, 8));
          1:       push_req(FN_RSVD_B, r, $urandom_range(0, 8));
          default: push_req(FN_RSVD_C, r, $urandom_range(0, 8));
        endcase
      end else if (sel < 13) begin
        push_req(FN_DUMP, r, $urandom_range(0, 8));
      end else if (sel < 28) begin
        if ($urandom_range(0, 3) == 0) r.key = $urandom;
        push_req(FN_SEARCH, r, $urandom_range(0, 8));
      end else if (sel < (grow ? 45 : 80)) begin
        push_req(FN_DELETE, r, $urandom_range(0, 8));
      end else if (sel < (grow ? 72 : 90)) begin
        push_req(FN_APPEND, r, $urandom_range(0, 8));
      end else begin
        push_req(FN_INSERT, r, $urandom_range(0, 8));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all words sent and every answer in, then let the block settle
    while (backlog.size() != 0 || req_bus.valid || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d answer words never arrived", $time, due_results.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/brl_pkg.sv
design/brl_if.sv
design/brl_ram.sv
design/bounded_record_list.sv
tb/sv/bounded_record_list_tb.sv
